// ----- sv/route_time_window_cost_evaluator_unit_assert.svh -----
// Assertion macros used by the file that carries the concurrent checks.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ROUTE_TIME_WINDOW_COST_EVALUATOR_UNIT_ASSERT_SVH
`define ROUTE_TIME_WINDOW_COST_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RTWCE_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define RTWCE_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- sv/rtwce_pkg.sv -----
package rtwce_pkg;

	localparam logic [29:0] MAX30 = 30'h3FFF_FFFF;
	localparam logic [23:0] MAX24 = 24'hFF_FFFF;
	localparam logic [9:0]  MAX10 = 10'h3FF;

	// Register index, taken from paddr[2].
	typedef enum logic [0:0] {
		REG_VEHICLE_CAPACITY = 1'b0,
		REG_DEPOT_LATEST     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] vehicle_capacity;
		logic [29:0] depot_latest;
	} cfg_t;

	typedef struct packed {
		logic        first_of_route;
		logic        last_of_route;
		logic        last_of_solution;
		logic [29:0] route_release;
		logic [23:0] dist_from_prev;
		logic [23:0] dist_to_depot;
		logic [15:0] demand;
		logic [23:0] service_duration;
		logic [29:0] window_early;
		logic [29:0] window_late;
	} in_item_t;

	// Route figures after the window check of one client.
	typedef struct packed {
		logic        last_route;
		logic        last_of_solution;
		logic [29:0] distance;
		logic [23:0] load;
		logic [29:0] warp;
		logic [29:0] clock_time;
		logic [23:0] service;
		logic [23:0] dist_to_depot;
	} route_fig_t;

	typedef struct packed {
		logic [29:0] route_distance;
		logic [23:0] route_load;
		logic [29:0] route_time_warp;
		logic [29:0] total_distance;
		logic [29:0] total_time_warp;
		logic [23:0] total_excess;
		logic [9:0]  route_count;
		logic        solution_done;
	} result_t;

	function automatic logic [29:0] sat30(input logic [31:0] v);
		return (v > {2'b00, MAX30}) ? MAX30 : v[29:0];
	endfunction

	function automatic logic [23:0] sat24(input logic [24:0] v);
		return (v > {1'b0, MAX24}) ? MAX24 : v[23:0];
	endfunction

endpackage

// ----- sv/rtwce_cfg.sv -----
module rtwce_cfg
	import rtwce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vehicle_capacity <= '0;
			cfg_q.depot_latest     <= MAX30;
		end else if (wr_en) begin
			case (idx)
				REG_VEHICLE_CAPACITY: cfg_q.vehicle_capacity <= pwdata[23:0];
				REG_DEPOT_LATEST:     cfg_q.depot_latest     <= pwdata[29:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_VEHICLE_CAPACITY: prdata = {8'b0, cfg_q.vehicle_capacity};
			REG_DEPOT_LATEST:     prdata = {2'b0, cfg_q.depot_latest};
			default:              prdata = '0;
		endcase
	end

endmodule

// ----- sv/rtwce_route_stage.sv -----
module rtwce_route_stage
	import rtwce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       fig_valid,
	input  logic       fig_ready,
	output route_fig_t fig
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       valid_s2;
	route_fig_t fig_s2;

	logic [29:0] clock_q;
	logic [23:0] prev_service_q;
	logic [29:0] dist_q;
	logic [23:0] load_q;
	logic [29:0] warp_q;

	logic        go_s1;
	logic        last_route;
	logic [29:0] dist_n;
	logic [23:0] load_n;
	logic [29:0] warp_n;
	logic [29:0] warp_w;
	logic [31:0] t_raw;
	logic [31:0] t_wait;
	logic [29:0] t_fin;

	assign go_s1      = valid_s1 && (!valid_s2 || fig_ready);
	assign item_ready = !valid_s1 || go_s1;
	assign last_route = item_s1.last_of_route || item_s1.last_of_solution;
	assign fig_valid  = valid_s2;
	assign fig        = fig_s2;

	always_comb begin
		if (item_s1.first_of_route) begin
			dist_n = {6'b0, item_s1.dist_from_prev};
			load_n = {8'b0, item_s1.demand};
			warp_n = '0;
			t_raw  = 32'(item_s1.route_release) + 32'(item_s1.dist_from_prev);
		end else begin
			dist_n = sat30(32'(dist_q) + 32'(item_s1.dist_from_prev));
			load_n = sat24(25'(load_q) + 25'(item_s1.demand));
			warp_n = warp_q;
			t_raw  = 32'(clock_q) + 32'(prev_service_q) + 32'(item_s1.dist_from_prev);
		end
		// Arrival before the window opens waits; arrival after it closes is warped back.
		t_wait = (t_raw < 32'(item_s1.window_early)) ? 32'(item_s1.window_early) : t_raw;
		if (t_wait > 32'(item_s1.window_late)) begin
			warp_w = sat30(32'(warp_n) + (t_wait - 32'(item_s1.window_late)));
			t_fin  = item_s1.window_late;
		end else begin
			warp_w = warp_n;
			t_fin  = t_wait[29:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || fig_ready) begin
			valid_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			fig_s2.last_route       <= last_route;
			fig_s2.last_of_solution <= item_s1.last_of_solution;
			fig_s2.distance         <= dist_n;
			fig_s2.load             <= load_n;
			fig_s2.warp             <= warp_w;
			fig_s2.clock_time       <= t_fin;
			fig_s2.service          <= item_s1.service_duration;
			fig_s2.dist_to_depot    <= item_s1.dist_to_depot;
		end
	end

	// A finished route leaves the route state empty for whatever follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q        <= '0;
			prev_service_q <= '0;
			dist_q         <= '0;
			load_q         <= '0;
			warp_q         <= '0;
		end else if (go_s1) begin
			if (last_route) begin
				clock_q        <= '0;
				prev_service_q <= '0;
				dist_q         <= '0;
				load_q         <= '0;
				warp_q         <= '0;
			end else begin
				clock_q        <= t_fin;
				prev_service_q <= item_s1.service_duration;
				dist_q         <= dist_n;
				load_q         <= load_n;
				warp_q         <= warp_w;
			end
		end
	end

endmodule

// ----- sv/rtwce_total_stage.sv -----
module rtwce_total_stage
	import rtwce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       fig_valid,
	output logic       fig_ready,
	input  route_fig_t fig,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    res
);

	logic        res_valid_s3;
	result_t     res_s3;
	logic [29:0] tot_dist_q;
	logic [29:0] tot_warp_q;
	logic [23:0] tot_excess_q;
	logic [9:0]  count_q;

	logic        adv;
	logic        take;
	logic [29:0] dist_fin;
	logic [31:0] ret;
	logic [29:0] warp_fin;
	logic [23:0] excess;
	logic [29:0] tot_dist_n;
	logic [29:0] tot_warp_n;
	logic [23:0] tot_excess_n;
	logic [9:0]  count_n;

	assign adv          = !res_valid_s3 || result_ready;
	// A client that does not end its route leaves no result and is always taken.
	assign fig_ready    = !fig.last_route || adv;
	assign take         = fig_valid && fig.last_route && adv;
	assign result_valid = res_valid_s3;
	assign res          = res_s3;

	always_comb begin
		dist_fin = sat30(32'(fig.distance) + 32'(fig.dist_to_depot));
		ret      = 32'(fig.clock_time) + 32'(fig.service) + 32'(fig.dist_to_depot);
		if (ret > 32'(cfg.depot_latest)) begin
			warp_fin = sat30(32'(fig.warp) + (ret - 32'(cfg.depot_latest)));
		end else begin
			warp_fin = fig.warp;
		end
		excess       = (fig.load > cfg.vehicle_capacity) ? fig.load - cfg.vehicle_capacity : '0;
		tot_dist_n   = sat30(32'(tot_dist_q) + 32'(dist_fin));
		tot_warp_n   = sat30(32'(tot_warp_q) + 32'(warp_fin));
		tot_excess_n = sat24(25'(tot_excess_q) + 25'(excess));
		count_n      = (count_q == MAX10) ? count_q : count_q + 10'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (adv) begin
			res_valid_s3 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s3.route_distance  <= dist_fin;
			res_s3.route_load      <= fig.load;
			res_s3.route_time_warp <= warp_fin;
			res_s3.total_distance  <= tot_dist_n;
			res_s3.total_time_warp <= tot_warp_n;
			res_s3.total_excess    <= tot_excess_n;
			res_s3.route_count     <= count_n;
			res_s3.solution_done   <= fig.last_of_solution;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_dist_q   <= '0;
			tot_warp_q   <= '0;
			tot_excess_q <= '0;
			count_q      <= '0;
		end else if (take) begin
			if (fig.last_of_solution) begin
				tot_dist_q   <= '0;
				tot_warp_q   <= '0;
				tot_excess_q <= '0;
				count_q      <= '0;
			end else begin
				tot_dist_q   <= tot_dist_n;
				tot_warp_q   <= tot_warp_n;
				tot_excess_q <= tot_excess_n;
				count_q      <= count_n;
			end
		end
	end

endmodule

// ----- sv/route_time_window_cost_evaluator_unit.sv -----
// Evaluates routes of a vehicle routing solution with time windows, one client per
// transaction in route order, and produces one result transaction per finished route
// carrying that route's distance, load and time warp together with the running solution
// totals. Clients are accepted back to back, one per clock, as long as results are taken;
// a client passes an input register, a route stage that keeps the route clock and sums,
// and a totals stage with the output register, and a result becomes valid once the client
// that ends its route has passed all three. The one-client-per-cycle rate is set by the
// route clock update: arrival, wait, and the clamp to the window close are combinational
// in the route stage. A full output register stalls clients that end a route, and those
// behind them. Vehicle capacity and depot deadline must be written over the register port
// only while no transaction is in flight; the user must keep to this, the block does not.
module route_time_window_cost_evaluator_unit
	import rtwce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        first_of_route,
	input  logic        last_of_route,
	input  logic        last_of_solution,
	input  logic [29:0] route_release,
	input  logic [23:0] dist_from_prev,
	input  logic [23:0] dist_to_depot,
	input  logic [15:0] demand,
	input  logic [23:0] service_duration,
	input  logic [29:0] window_early,
	input  logic [29:0] window_late,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [29:0] route_distance,
	output logic [23:0] route_load,
	output logic [29:0] route_time_warp,
	output logic [29:0] total_distance,
	output logic [29:0] total_time_warp,
	output logic [23:0] total_excess,
	output logic [9:0]  route_count,
	output logic        solution_done
);

	cfg_t       cfg;
	in_item_t   item;
	route_fig_t fig;
	logic       fig_valid;
	logic       fig_ready;
	result_t    res;

	assign item.first_of_route   = first_of_route;
	assign item.last_of_route    = last_of_route;
	assign item.last_of_solution = last_of_solution;
	assign item.route_release    = route_release;
	assign item.dist_from_prev   = dist_from_prev;
	assign item.dist_to_depot    = dist_to_depot;
	assign item.demand           = demand;
	assign item.service_duration = service_duration;
	assign item.window_early     = window_early;
	assign item.window_late      = window_late;

	assign route_distance  = res.route_distance;
	assign route_load      = res.route_load;
	assign route_time_warp = res.route_time_warp;
	assign total_distance  = res.total_distance;
	assign total_time_warp = res.total_time_warp;
	assign total_excess    = res.total_excess;
	assign route_count     = res.route_count;
	assign solution_done   = res.solution_done;

	rtwce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtwce_route_stage u_route (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.fig_valid  (fig_valid),
		.fig_ready  (fig_ready),
		.fig        (fig)
	);

	rtwce_total_stage u_total (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.fig_valid    (fig_valid),
		.fig_ready    (fig_ready),
		.fig          (fig),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.res          (res)
	);

endmodule

// ----- sv/rtwce_checker.sv -----
`include "route_time_window_cost_evaluator_unit_assert.svh"

module rtwce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [29:0] route_distance,
	input logic [29:0] route_time_warp,
	input logic [29:0] total_distance,
	input logic [29:0] total_time_warp,
	input logic [9:0]  route_count,
	input logic        solution_done
);

	// A stalled result must hold until it is taken.
	`RTWCE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(route_distance) && $stable(total_distance) && $stable(route_count) && $stable(solution_done), "result changed while stalled")

	// Every result closes at least one route.
	`RTWCE_ASSERT_NOW(a_count_nonzero, result_valid, route_count != 10'd0, "result with zero route count")

	// The totals include the route just finished.
	`RTWCE_ASSERT_NOW(a_totals_cover_route, result_valid, (total_distance >= route_distance) && (total_time_warp >= route_time_warp), "totals below route figures")

	// The first route of a solution starts the totals afresh.
	`RTWCE_ASSERT_NOW(a_first_route_totals, result_valid && (route_count == 10'd1), (total_distance == route_distance) && (total_time_warp == route_time_warp), "first route totals differ from route figures")

endmodule

bind route_time_window_cost_evaluator_unit rtwce_checker u_rtwce_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import rtwce_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned WATCHDOG_LIMIT = 500;
	localparam int unsigned LONG_ROUTE = 260;
	localparam int unsigned SHORT_ROUTES = 1030;
	localparam int unsigned RANDOM_PHASES = 5;
	localparam int unsigned CLIENTS_PER_PHASE = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        first_of_route = 1'b0;
	logic        last_of_route = 1'b0;
	logic        last_of_solution = 1'b0;
	logic [29:0] route_release = '0;
	logic [23:0] dist_from_prev = '0;
	logic [23:0] dist_to_depot = '0;
	logic [15:0] demand = '0;
	logic [23:0] service_duration = '0;
	logic [29:0] window_early = '0;
	logic [29:0] window_late = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [29:0] route_distance;
	logic [23:0] route_load;
	logic [29:0] route_time_warp;
	logic [29:0] total_distance;
	logic [29:0] total_time_warp;
	logic [23:0] total_excess;
	logic [9:0]  route_count;
	logic        solution_done;

	// Register copies and route state held by the predictor.
	logic [23:0] capacity_limit = '0;
	logic [29:0] depot_deadline = MAX30;
	logic [29:0] route_clock = '0;
	logic [23:0] route_prev_service = '0;
	logic [29:0] route_dist = '0;
	logic [23:0] route_load_sum = '0;
	logic [29:0] route_warp = '0;
	logic [29:0] sol_dist = '0;
	logic [29:0] sol_warp = '0;
	logic [23:0] sol_excess = '0;
	logic [9:0]  sol_routes = '0;

	result_t     route_results_due[$];
	int unsigned mismatch_count = 0;
	int unsigned clients_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_hold = 0;
	bit          tx_no_gaps = 1'b0;
	bit          rx_no_stalls = 1'b0;

	route_time_window_cost_evaluator_unit dut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] top);
		logic [63:0] s;
		s = a + b;
		return (s > top) ? top : s;
	endfunction

	task automatic evaluate_client(input in_item_t c);
		logic [63:0] t;
		logic [63:0] arrival_home;
		logic [23:0] excess;
		result_t     r;
		if (c.first_of_route) begin
			route_dist = 30'(c.dist_from_prev);
			route_load_sum = 24'(c.demand);
			route_warp = '0;
			t = 64'(c.route_release) + 64'(c.dist_from_prev);
		end else begin
			route_dist = 30'(capped_sum(64'(route_dist), 64'(c.dist_from_prev), 64'(MAX30)));
			route_load_sum = 24'(capped_sum(64'(route_load_sum), 64'(c.demand), 64'(MAX24)));
			t = 64'(route_clock) + 64'(route_prev_service) + 64'(c.dist_from_prev);
		end
		if (t < 64'(c.window_early))
			t = 64'(c.window_early);
		if (t > 64'(c.window_late)) begin
			route_warp = 30'(capped_sum(64'(route_warp), t - 64'(c.window_late), 64'(MAX30)));
			t = 64'(c.window_late);
		end
		route_clock = t[29:0];
		route_prev_service = c.service_duration;
		if (!(c.last_of_route || c.last_of_solution))
			return;

		arrival_home = 64'(route_clock) + 64'(c.service_duration) + 64'(c.dist_to_depot);
		route_dist = 30'(capped_sum(64'(route_dist), 64'(c.dist_to_depot), 64'(MAX30)));
		if (arrival_home > 64'(depot_deadline))
			route_warp = 30'(capped_sum(64'(route_warp), arrival_home - 64'(depot_deadline),
				64'(MAX30)));
		excess = (route_load_sum > capacity_limit) ? route_load_sum - capacity_limit : '0;
		sol_dist = 30'(capped_sum(64'(sol_dist), 64'(route_dist), 64'(MAX30)));
		sol_warp = 30'(capped_sum(64'(sol_warp), 64'(route_warp), 64'(MAX30)));
		sol_excess = 24'(capped_sum(64'(sol_excess), 64'(excess), 64'(MAX24)));
		sol_routes = 10'(capped_sum(64'(sol_routes), 64'd1, 64'(MAX10)));

		r.route_distance = route_dist;
		r.route_load = route_load_sum;
		r.route_time_warp = route_warp;
		r.total_distance = sol_dist;
		r.total_time_warp = sol_warp;
		r.total_excess = sol_excess;
		r.route_count = sol_routes;
		r.solution_done = c.last_of_solution;
		route_results_due.insert(route_results_due.size(), r);

		route_clock = '0;
		route_prev_service = '0;
		route_dist = '0;
		route_load_sum = '0;
		route_warp = '0;
		if (c.last_of_solution) begin
			sol_dist = '0;
			sol_warp = '0;
			sol_excess = '0;
			sol_routes = '0;
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	task automatic check_route_result();
		result_t want;
		if (route_results_due.size() == 0) begin
			compare_field("unexpected result_valid", 64'd0, 64'd1);
			return;
		end
		want = route_results_due[0];
		route_results_due.delete(0);
		compare_field("route_distance", 64'(want.route_distance), 64'(route_distance));
		compare_field("route_load", 64'(want.route_load), 64'(route_load));
		compare_field("route_time_warp", 64'(want.route_time_warp), 64'(route_time_warp));
		compare_field("total_distance", 64'(want.total_distance), 64'(total_distance));
		compare_field("total_time_warp", 64'(want.total_time_warp), 64'(total_time_warp));
		compare_field("total_excess", 64'(want.total_excess), 64'(total_excess));
		compare_field("route_count", 64'(want.route_count), 64'(route_count));
		compare_field("solution_done", 64'(want.solution_done), 64'(solution_done));
	endtask

	// Result side: after each transaction the sink holds ready low for a drawn number of cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (result_valid && result_ready) begin
			check_route_result();
			rx_hold = rx_no_stalls ? 0 : $urandom_range(0, 6);
			result_ready <= (rx_hold == 0);
		end else if (rx_hold != 0) begin
			rx_hold--;
			result_ready <= (rx_hold == 0);
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Within this task valid is only lowered when a gap is drawn, so back-to-back clients keep it high.
	task automatic send_client(input in_item_t c);
		int unsigned gap;
		gap = tx_no_gaps ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		first_of_route <= c.first_of_route;
		last_of_route <= c.last_of_route;
		last_of_solution <= c.last_of_solution;
		route_release <= c.route_release;
		dist_from_prev <= c.dist_from_prev;
		dist_to_depot <= c.dist_to_depot;
		demand <= c.demand;
		service_duration <= c.service_duration;
		window_early <= c.window_early;
		window_late <= c.window_late;
		do @(posedge clk); while (!item_ready);
		evaluate_client(c);
		clients_sent++;
	endtask

	task automatic wait_for_idle();
		item_valid <= 1'b0;
		while (route_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_register(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] width_mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_VEHICLE_CAPACITY) begin
			capacity_limit = value[23:0];
			width_mask = {8'h00, MAX24};
		end else begin
			depot_deadline = value[29:0];
			width_mask = {2'b00, MAX30};
		end
		// Read the register straight back with a second transfer.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field(idx == REG_VEHICLE_CAPACITY ? "vehicle_capacity read" : "depot_latest read",
			64'(value & width_mask), 64'(prdata & width_mask));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t mk_client(input logic f, input logic l, input logic s,
			input logic [29:0] rel, input logic [23:0] dprev, input logic [23:0] dhome,
			input logic [15:0] dem, input logic [23:0] serv, input logic [29:0] early,
			input logic [29:0] late);
		in_item_t c;
		c.first_of_route = f;
		c.last_of_route = l;
		c.last_of_solution = s;
		c.route_release = rel;
		c.dist_from_prev = dprev;
		c.dist_to_depot = dhome;
		c.demand = dem;
		c.service_duration = serv;
		c.window_early = early;
		c.window_late = late;
		return c;
	endfunction

	// Mostly values of the size real routes have, with zeros, tops and full-width noise mixed in.
	function automatic logic [31:0] rand_value(input int unsigned bits, input int unsigned typical);
		logic [31:0] top;
		top = (32'd1 << bits) - 32'd1;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return top;
			2, 3: return $urandom & top;
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	function automatic in_item_t rand_client(input logic f, input logic l, input logic s);
		logic [29:0] early;
		logic [29:0] late;
		early = 30'(rand_value(30, 5000));
		late = ($urandom_range(0, 3) == 0) ? 30'(rand_value(30, 5000))
			: 30'(32'(early) + $urandom_range(0, 1500));
		return mk_client(f, l, s, 30'(rand_value(30, 2000)), 24'(rand_value(24, 400)),
			24'(rand_value(24, 400)), 16'(rand_value(16, 300)), 24'(rand_value(24, 200)),
			early, late);
	endfunction

	task automatic test_basic_routes();
		// A route of nothing at all.
		send_client(mk_client(1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		// Three clients: a wait at an early window, then warp at a late one.
		send_client(mk_client(1, 0, 0, 100, 10, 0, 5, 20, 200, 300));
		send_client(mk_client(0, 0, 0, 0, 30, 0, 7, 10, 0, 100));
		send_client(mk_client(0, 1, 0, 0, 5, 40, 9, 15, 0, MAX30));
		// A window that opens after it closes.
		send_client(mk_client(1, 1, 0, 0, 1, 2, 3, 4, 500, 100));
		// A first flag in the middle of a route drops the partial route.
		send_client(mk_client(1, 0, 0, 50, 60, 0, 70, 80, 0, 1000));
		send_client(mk_client(0, 0, 0, 0, 20, 0, 30, 40, 0, 1000));
		send_client(mk_client(1, 1, 0, 10, 20, 30, 40, 50, 0, 1000));
		// No first flag after a route end: the client joins an empty route at clock zero.
		send_client(mk_client(0, 1, 0, 777, 12, 3, 4, 5, 0, 1000));
		// The end of the solution closes the route on its own.
		send_client(mk_client(1, 0, 1, 5, 6, 7, 8, 9, 0, 100));
		// Distances, demand and service at their tops, with and without the flags, then an all-zero end.
		send_client(mk_client(1, 0, 0, MAX30, MAX24, MAX24, 16'hFFFF, MAX24, MAX30, MAX30));
		send_client(mk_client(0, 1, 1, MAX30, MAX24, MAX24, 16'hFFFF, MAX24, 0, 0));
		send_client(mk_client(1, 1, 1, MAX30, MAX24, MAX24, 16'hFFFF, MAX24, MAX30, MAX30));
		send_client(mk_client(1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_deadline_and_capacity();
		wait_for_idle();
		program_register(REG_VEHICLE_CAPACITY, 32'd100);
		program_register(REG_DEPOT_LATEST, 32'd0);
		send_client(mk_client(1, 0, 0, 0, 10, 0, 60, 5, 0, 1000));
		send_client(mk_client(0, 1, 0, 0, 10, 20, 50, 5, 0, 1000));
		send_client(mk_client(1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
		wait_for_idle();
		program_register(REG_VEHICLE_CAPACITY, 32'd500);
		program_register(REG_DEPOT_LATEST, 32'd1000);
		// Exactly on capacity and deadline, then one over each.
		send_client(mk_client(1, 1, 0, 0, 100, 100, 500, 800, 0, 1000));
		send_client(mk_client(1, 1, 1, 0, 100, 101, 501, 800, 0, 1000));
		wait_for_idle();
		program_register(REG_VEHICLE_CAPACITY, '1);
		program_register(REG_DEPOT_LATEST, '1);
		send_client(mk_client(1, 1, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
		send_client(mk_client(1, 1, 1, MAX30, MAX24, MAX24, 16'hFFFF, MAX24, 0, MAX30));
	endtask

	task automatic test_saturation();
		wait_for_idle();
		program_register(REG_VEHICLE_CAPACITY, '0);
		program_register(REG_DEPOT_LATEST, {2'b00, MAX30});
		// Long enough to pin route distance, load and excess at their tops.
		for (int k = 0; k < LONG_ROUTE; k++)
			send_client(mk_client(k == 0, k == LONG_ROUTE - 1, 1'b0, '0, MAX24, MAX24, 16'hFFFF,
				'0, '0, MAX30));
		// Enough routes in one solution to pin the route count.
		for (int k = 0; k < SHORT_ROUTES; k++) begin
			if (k % 64 == 0) begin
				tx_no_gaps = ($urandom_range(0, 3) == 0);
				rx_no_stalls = ($urandom_range(0, 3) == 0);
			end
			send_client(rand_client(1'b1, 1'b1, k == SHORT_ROUTES - 1));
		end
	endtask

	task automatic test_random_solutions();
		int unsigned phase_end;
		int unsigned routes;
		int unsigned stops;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_idle();
			case (phase)
				0: begin
					program_register(REG_VEHICLE_CAPACITY, '0);
					program_register(REG_DEPOT_LATEST, '0);
				end
				1: begin
					program_register(REG_VEHICLE_CAPACITY, '1);
					program_register(REG_DEPOT_LATEST, '1);
				end
				2: begin
					program_register(REG_VEHICLE_CAPACITY, $urandom_range(0, 1500));
					program_register(REG_DEPOT_LATEST, $urandom_range(0, 30000));
				end
				3: begin
					program_register(REG_VEHICLE_CAPACITY, $urandom);
					program_register(REG_DEPOT_LATEST, $urandom);
				end
				default: begin
					program_register(REG_VEHICLE_CAPACITY, $urandom_range(200, 2000));
					program_register(REG_DEPOT_LATEST, $urandom_range(5000, 100000));
				end
			endcase
			phase_end = clients_sent + CLIENTS_PER_PHASE;
			while (clients_sent < phase_end) begin
				tx_no_gaps = ($urandom_range(0, 3) == 0);
				rx_no_stalls = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 7) == 0) begin
					// Stray clients with arbitrary flags, which break routes apart.
					repeat ($urandom_range(1, 4))
						send_client(rand_client(1'($urandom), 1'($urandom),
							$urandom_range(0, 3) == 0));
				end else begin
					routes = $urandom_range(1, 6);
					for (int r = 0; r < routes; r++) begin
						stops = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
							: $urandom_range(1, 6);
						for (int k = 0; k < stops; k++)
							send_client(rand_client(k == 0,
								k == stops - 1 && (r != routes - 1 || $urandom_range(0, 1) == 1),
								k == stops - 1 && r == routes - 1));
					end
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_routes();
		test_deadline_and_capacity();
		test_saturation();
		test_random_solutions();
		wait_for_idle();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
